/* rtl/core/tpkc_pkg.sv */
// Shared types and constants for the threshold-promote key cache.
// Holds the word structs of both channels, the controller command struct and
// the configuration register indexes. Depends on nothing.
`default_nettype none

package tpkc_pkg;

    // Field widths fixed by the channel definition.
    localparam int KEY_W    = 32;
    localparam int POS_W    = 4;
    localparam int HITS_W   = 16;
    localparam int OCC_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [HITS_W-1:0] THRESHOLD_RST = 16'd5;
    localparam logic [OCC_W-1:0]  CAPACITY_RST  = 5'd4;

    // Input command codes.
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Input word.
    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  found_position;
        logic [HITS_W-1:0] count_after;
        logic              promoted;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic [OCC_W-1:0]  occupancy;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the input word and latch the search result
        logic commit;    // update the list and load the result word
    } tpkc_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/threshold_promote_key_cache_top.sv */
// Top level of the threshold-promote key cache (move-to-front list cache).
// Instantiates tpkc_ctrl and tpkc_dp; uses tpkc_pkg for word types.
//
//   channel   direction  handshake            word
//   s_        in         s_valid / s_ready    tpkc_pkg::in_word_t  (cmd, key)
//   m_        out        m_valid / m_ready    tpkc_pkg::out_word_t (result)
//   cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// Each word is handled in an acceptance step, which searches all held entries
// in parallel, and an update step, which shifts the list and loads the result register.
// A new word is taken in the cycle after the update, even while the last result waits.
// A stalled result register holds the update step until it is taken.
// Reset is synchronous and needs no clearing pass; the list starts empty.
`default_nettype none

module threshold_promote_key_cache_top #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [tpkc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tpkc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire tpkc_pkg::in_word_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output tpkc_pkg::out_word_t                   m_data
);
    import tpkc_pkg::*;

    // Capacity in use is a 5-bit register, so no more than 31 entries are ever held.
    localparam int DEPTH = (CAPACITY < 31) ? CAPACITY : 31;

    tpkc_cmd_t cmd;

    tpkc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tpkc_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

/* rtl/core/tpkc_ctrl.sv */
// Controller of the key cache: two-state sequencer and result-valid flag.
// Depends on tpkc_pkg for the command struct.
`default_nettype none

module tpkc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output tpkc_pkg::tpkc_cmd_t   cmd
);
    import tpkc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // The result register can be loaded when empty or being emptied now.
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.capture = s_valid && s_ready;
    assign cmd.commit  = (state_reg == ST_UPDATE) && out_free;

    // Next state: accept in idle, commit once the result register is free.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result-valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // An accepted word is always followed by the update step.
    a_accept_then_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_UPDATE))
        else $error("accepted word not followed by update");

    // A commit never overwrites a result that is still waiting.
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("commit while result register busy");

    // A commit always presents a result in the next cycle.
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("commit did not raise result valid");

endmodule

`default_nettype wire

/* rtl/core/tpkc_dp.sv */
// Datapath of the key cache: configuration registers, the ordered key list,
// parallel search, list shifting and the result register. Uses tpkc_pkg.
`default_nettype none

module tpkc_dp #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [tpkc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tpkc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire tpkc_pkg::in_word_t                  s_data,
    input  wire tpkc_pkg::tpkc_cmd_t                 cmd,
    output tpkc_pkg::out_word_t                      m_data
);
    import tpkc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH + 1);
    localparam logic [OCC_W-1:0] DEPTH_CAP = OCC_W'(DEPTH);

    // Configuration registers.
    logic [HITS_W-1:0] threshold_reg;
    logic [OCC_W-1:0]  capacity_reg;

    // The list, front at entry 0.
    logic [KEY_BITS-1:0] entry_key_reg  [DEPTH];
    logic [HITS_W-1:0]   entry_hits_reg [DEPTH];
    logic [HW-1:0]       held_reg, held_next;

    // Word under work, latched at acceptance together with the search result.
    logic                cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                found_reg;
    logic [PW-1:0]       pos_reg;
    logic [HITS_W-1:0]   hits_reg;

    out_word_t           out_reg, out_next;

    logic [KEY_BITS-1:0] key_in;
    logic                found_c;
    logic [PW-1:0]       pos_c;
    logic [HITS_W-1:0]   hits_c;

    logic [OCC_W-1:0]    eff_cap;
    logic                promote;
    logic                evict;
    logic [PW-1:0]       last_pos;
    logic [HW-1:0]       held_kept;
    logic [HITS_W-1:0]   hits_inc;
    logic [DEPTH-1:0]    shift_en;
    logic                write_front;
    logic [HITS_W-1:0]   front_hits;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            capacity_reg  <= CAPACITY_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_wdata;
                REG_CAPACITY:  capacity_reg  <= cfg_wdata[OCC_W-1:0];
                default:       ;
            endcase
        end
    end

    // Search of the held entries on the incoming key; the front match wins.
    assign key_in = KEY_BITS'(s_data.key);

    always_comb begin
        found_c = 1'b0;
        pos_c   = '0;
        hits_c  = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if ((HW'(i) < held_reg) && (entry_key_reg[i] == key_in)) begin
                found_c = 1'b1;
                pos_c   = PW'(i);
                hits_c  = entry_hits_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= s_data.cmd;
            key_reg   <= key_in;
            found_reg <= found_c;
            pos_reg   <= pos_c;
            hits_reg  <= hits_c;
        end
    end

    // Capacity in force: zero acts as one, and it never exceeds the storage.
    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = OCC_W'(1);
        end else if (capacity_reg > DEPTH_CAP) begin
            eff_cap = DEPTH_CAP;
        end else begin
            eff_cap = capacity_reg;
        end
    end

    // Update decisions for the word under work. A miss overflows when the list
    // already holds the capacity in force or more.
    assign hits_inc  = (hits_reg == HITS_MAX) ? hits_reg : hits_reg + 1'b1;
    assign promote   = found_reg && (hits_reg >= threshold_reg) && (pos_reg != '0);
    assign evict     = !found_reg && (held_reg != '0)
                       && (OCC_W'(held_reg) >= eff_cap);
    assign last_pos  = PW'(held_reg - 1'b1);
    assign held_kept = evict ? (held_reg - 1'b1) : held_reg;

    // A miss pushes the whole list back; a promotion only the entries ahead of it.
    always_comb begin
        shift_en[0] = 1'b0;
        for (int i = 1; i < DEPTH; i++) begin
            shift_en[i] = !found_reg || (promote && (PW'(i) <= pos_reg));
        end
    end

    assign write_front = !found_reg || promote;
    assign front_hits  = found_reg ? hits_inc : HITS_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.commit && (cmd_reg == CMD_ACCESS)) begin
            for (int i = 1; i < DEPTH; i++) begin
                if (shift_en[i]) begin
                    entry_key_reg[i]  <= entry_key_reg[i-1];
                    entry_hits_reg[i] <= entry_hits_reg[i-1];
                end
            end
            if (write_front) begin
                entry_key_reg[0]  <= key_reg;
                entry_hits_reg[0] <= front_hits;
            end else begin
                entry_hits_reg[pos_reg] <= hits_inc;
            end
        end
    end

    // Occupancy.
    always_comb begin
        held_next = held_reg;
        if (cmd.commit) begin
            if (cmd_reg == CMD_CLEAR) begin
                held_next = '0;
            end else if (!found_reg) begin
                held_next = held_kept + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

    // Result word; a clear reports all zeros.
    always_comb begin
        out_next = '0;
        if (cmd_reg == CMD_ACCESS) begin
            out_next.hit            = found_reg;
            out_next.found_position = found_reg ? POS_W'(pos_reg) : '0;
            out_next.count_after    = front_hits;
            out_next.promoted       = promote;
            out_next.evicted        = evict;
            out_next.evicted_key    = evict ? KEY_W'(entry_key_reg[last_pos]) : '0;
            out_next.occupancy      = found_reg ? OCC_W'(held_reg)
                                                : OCC_W'(held_kept + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // The list never holds more entries than storage.
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= HW'(DEPTH))
        else $error("occupancy beyond storage");

    // A committed clear empties the list.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (cmd_reg == CMD_CLEAR)) |=> (held_reg == '0))
        else $error("clear left entries");

    // A hit never changes the occupancy.
    a_hit_keeps_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (cmd_reg == CMD_ACCESS) && found_reg) |=> $stable(held_reg))
        else $error("hit changed occupancy");

endmodule

`default_nettype wire
